// File: rtl/core/positional_list_store_macros.svh
// Shared assertion macros
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

// Same-cycle implication
`define PLST_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("plst check failed");

// Next-cycle implication
`define PLST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("plst check failed");

`endif

// File: rtl/core/plst_pkg.sv
package plst_pkg;

    localparam int POS_W      = 7;
    localparam int ENTRY_W    = 32;
    localparam int LEN_W      = 7;
    localparam int FUNC_W     = 3;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 48;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT  = 3'd0,
        FUNC_REMOVE  = 3'd1,
        FUNC_GET     = 3'd2,
        FUNC_REPLACE = 3'd3,
        FUNC_CLEAR   = 3'd4
    } func_t;

    typedef logic [POS_W-1:0] slot_t;

    // broadcast to every cell; slot is position - 1
    typedef struct packed {
        logic  shift_up;
        logic  shift_down;
        logic  write;
        slot_t slot;
    } cmd_t;

endpackage

// File: rtl/core/plst_cell.sv
module plst_cell #(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  plst_pkg::cmd_t        cmd,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] q,
    output logic [DATA_WIDTH-1:0] rd_tap
);
    import plst_pkg::*;

    localparam bit    FAR  = (IDX >= (1 << POS_W));
    localparam slot_t IDX7 = POS_W'(IDX);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    logic                  hit;
    logic                  above;

    assign hit   = !FAR && (cmd.slot == IDX7);
    assign above = FAR || (IDX7 > cmd.slot);

    always_comb begin
        entry_next = entry_reg;
        if (cmd.shift_up) begin
            if (hit) begin
                entry_next = wr_data;
            end else if (above) begin
                entry_next = left_data;
            end
        end else if (cmd.shift_down) begin
            if (hit || above) begin
                entry_next = right_data;
            end
        end else if (cmd.write && hit) begin
            entry_next = wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign q      = entry_reg;
    assign rd_tap = hit ? entry_reg : '0;

endmodule

// File: rtl/core/positional_list_store.sv
// The result of an input transfer is registered onto the m_ side in the next cycle.
// Throughput: one operation per cycle unless m_tready stalls the m_ side; every cell of
// the row shifts, loads or holds in the same cycle, and the read is an OR over the cell taps.
// Reset: aresetn (synchronous, active low) empties the list and drops m_tvalid;
// entry contents are not cleared and no clearing pass is needed.
module positional_list_store #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [plst_pkg::S_TDATA_W-1:0]  s_tdata,  // position[6:0], entry[38:7]
    input  logic [plst_pkg::FUNC_W-1:0]     s_tuser,  // func[2:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [plst_pkg::M_TDATA_W-1:0]  m_tdata   // ok, data, length, empty_res
);
    import plst_pkg::*;

    `include "positional_list_store_macros.svh"

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  m_valid_reg;
    logic                  ok_reg;
    logic [ENTRY_W-1:0]    data_reg;
    logic [LEN_W-1:0]      len_reg;
    logic                  empty_reg;

    logic                  fire;
    func_t                 func;
    logic [POS_W-1:0]      position;
    logic [ENTRY_W-1:0]    entry;
    logic [EW-1:0]         pos_e;
    logic [EW-1:0]         cnt_e;
    logic                  in_list;
    logic                  ins_ok;
    logic                  ok_c;
    logic                  read_op;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] rd_or;
    logic [ENTRY_W-1:0]    data_c;
    cmd_t                  cmd;

    logic [DATA_WIDTH-1:0] q    [CAPACITY];
    logic [DATA_WIDTH-1:0] taps [CAPACITY];

    assign func     = func_t'(s_tuser);
    assign position = s_tdata[POS_W-1:0];
    assign entry    = s_tdata[POS_W+ENTRY_W-1:POS_W];
    assign wr_data  = DATA_WIDTH'(entry);

    assign s_tready = !m_valid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;

    assign pos_e   = EW'(position);
    assign cnt_e   = EW'(count_reg);
    assign in_list = (pos_e != '0) && (pos_e <= cnt_e);
    assign ins_ok  = (cnt_e < EW'(CAPACITY)) && (pos_e != '0) && (pos_e <= cnt_e + EW'(1));

    always_comb begin
        ok_c    = 1'b0;
        read_op = 1'b0;
        cmd     = '0;
        cmd.slot = position - POS_W'(1);
        count_next = count_reg;
        case (func)
            FUNC_INSERT: begin
                ok_c         = ins_ok;
                cmd.shift_up = fire && ins_ok;
                if (fire && ins_ok) begin
                    count_next = count_reg + CW'(1);
                end
            end
            FUNC_REMOVE: begin
                ok_c           = in_list;
                cmd.shift_down = fire && in_list;
                if (fire && in_list) begin
                    count_next = count_reg - CW'(1);
                end
            end
            FUNC_GET: begin
                ok_c    = in_list;
                read_op = 1'b1;
            end
            FUNC_REPLACE: begin
                ok_c      = in_list;
                read_op   = 1'b1;
                cmd.write = fire && in_list;
            end
            FUNC_CLEAR: begin
                ok_c = 1'b1;
                if (fire) begin
                    count_next = '0;
                end
            end
            default: begin
                ok_c = 1'b0;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;
        if (g == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = q[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = q[g+1];
        end
        plst_cell #(
            .IDX        (g),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .wr_data    (wr_data),
            .left_data  (left_d),
            .right_data (right_d),
            .q          (q[g]),
            .rd_tap     (taps[g])
        );
    end

    always_comb begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_or = rd_or | taps[i];
        end
    end

    assign data_c = (ok_c && read_op) ? ENTRY_W'(rd_or) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            ok_reg    <= ok_c;
            data_reg  <= data_c;
            len_reg   <= LEN_W'(count_next);
            empty_reg <= (count_next == '0);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, empty_reg, len_reg, data_reg, ok_reg};

    `PLST_ASSERT_NOW(a_count_cap, aclk, aresetn, 1'b1, count_reg <= CW'(CAPACITY))
    `PLST_ASSERT_NEXT(a_clear_empties, aclk, aresetn, fire && (func == FUNC_CLEAR), count_reg == '0)
    `PLST_ASSERT_NEXT(a_reject_holds, aclk, aresetn, fire && !ok_c, $stable(count_reg))
    `PLST_ASSERT_NOW(a_reject_no_data, aclk, aresetn, m_valid_reg && !ok_reg, data_reg == '0)

endmodule
